// ===== sv/assert_macros.svh =====
// Assertion macros shared by the doorbell decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define DPWD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dpwd assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define DPWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpwd assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define DPWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpwd assertion failed");

`endif

// ===== sv/dpwd_pkg.sv =====
// Shared types, constants and helpers of the doorbell pulse-width decoder.
package dpwd_pkg;

  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_PULSE_MID = 2'd0;
  localparam logic [1:0] REG_PULSE_MAX = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  localparam logic [15:0] RST_PULSE_MID = 16'd700;
  localparam logic [15:0] RST_PULSE_MAX = 16'd1900;
  localparam logic [15:0] RST_WINDOW    = 16'd1000;

  localparam logic [6:0] PULSE_COUNT     = 7'd66;
  localparam logic [6:0] LAST_PAIR_PULSE = 7'd64;
  localparam logic [6:0] PULSE_IDX_MAX   = 7'h7F;

  localparam logic [7:0] CHIME_BYTE_0 = 8'h03;
  localparam logic [7:0] CHIME_BYTE_1 = 8'hE0;
  localparam logic [7:0] CHIME_BYTE_2 = 8'h1C;

  typedef enum logic [1:0] {
    STATUS_NEW    = 2'd0,
    STATUS_REPEAT = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] pulse_duration;
    logic        last_pulse;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] device_id;
    logic [1:0]  chime_number;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pulse_mid;
    logic [15:0] pulse_max;
    logic [15:0] window_ms;
  } cfg_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic is_tick;
    logic last;
    logic above_mid;
    logic above_max;
    logic below_mid;
  } pulse_class_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
  } chime_t;

  function automatic chime_t chime_map(input logic [7:0] low_byte);
    chime_t c;
    c.valid = 1'b1;
    c.index = 2'd0;
    if (low_byte == CHIME_BYTE_0) begin
      c.index = 2'd0;
    end else if (low_byte == CHIME_BYTE_1) begin
      c.index = 2'd1;
    end else if (low_byte == CHIME_BYTE_2) begin
      c.index = 2'd2;
    end else begin
      c.valid = 1'b0;
    end
    return c;
  endfunction

endpackage

// ===== sv/doorbell_pulse_width_decoder.sv =====
// Top level of the doorbell pulse-width decoder: register bank, front, queue, back.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------------
//  in      | in_valid / in_ready    | in_data: req_type, pulse_duration, last_pulse
//  out     | out_valid / out_ready  | out_data: status, device_id, chime_number
//  cfg     | psel, penable, pwrite  | paddr / pwdata / prdata, regs at 0x0, 0x4, 0x8
//
//  Cycles: one beat per clock while out_ready keeps the result register draining; a
//    closing pulse's result shows on out_* after the queue slot and then the result register.
//  Stalls: a closing pulse at the queue head waits while the result register
//    is full and out_ready is low; in_ready drops once the queue fills up.
//  Reset: synchronous, active low; clears packet and repeat state, loads the
//    register defaults; pready is tied high and in_ready is high right after reset.
module doorbell_pulse_width_decoder #(
  parameter int unsigned QUEUE_DEPTH = dpwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input beats
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dpwd_pkg::in_item_t           in_data,
  // result beats
  output logic                         out_valid,
  input  logic                         out_ready,
  output dpwd_pkg::out_item_t          out_data,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpwd_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpwd_pkg::DATA_W-1:0]  pwdata,
  output logic [dpwd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import dpwd_pkg::*;

  cfg_t         cfg;
  logic         q_full;
  logic         q_push;
  pulse_class_t q_in;
  logic         q_pop;
  logic         q_valid;
  pulse_class_t q_head;

  // thresholds and repeat window; the user must write them only while the block is idle, the block does not enforce it
  dpwd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: take beats, reduce durations to short/long/too-long flags
  dpwd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // decouples acceptance from a stalled result register
  dpwd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // back: bit assembly, packet checks, repeat filter, result register
  dpwd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== sv/dpwd_cfg.sv =====
// APB register bank holding the pulse thresholds and repeat window.
module dpwd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dpwd_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpwd_pkg::DATA_W-1:0]  pwdata,
  output logic [dpwd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output dpwd_pkg::cfg_t               cfg
);
  import dpwd_pkg::*;

  logic [15:0] mid_r, mid_nxt;
  logic [15:0] max_r, max_nxt;
  logic [15:0] win_r, win_nxt;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    mid_nxt = mid_r;
    max_nxt = max_r;
    win_nxt = win_r;
    if (wr_en) begin
      case (reg_idx)
        REG_PULSE_MID: mid_nxt = pwdata[15:0];
        REG_PULSE_MAX: max_nxt = pwdata[15:0];
        REG_WINDOW:    win_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= RST_PULSE_MID;
      max_r <= RST_PULSE_MAX;
      win_r <= RST_WINDOW;
    end else begin
      mid_r <= mid_nxt;
      max_r <= max_nxt;
      win_r <= win_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSE_MID: prdata = {16'd0, mid_r};
      REG_PULSE_MAX: prdata = {16'd0, max_r};
      REG_WINDOW:    prdata = {16'd0, win_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.pulse_mid = mid_r;
  assign cfg.pulse_max = max_r;
  assign cfg.window_ms = win_r;

endmodule

// ===== sv/dpwd_front.sv =====
// Front end: accepts input beats and classifies pulse durations.
module dpwd_front (
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dpwd_pkg::in_item_t     in_data,
  input  dpwd_pkg::cfg_t         cfg,
  input  logic                   q_full,
  output logic                   q_push,
  output dpwd_pkg::pulse_class_t q_entry
);
  import dpwd_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // the user must keep thresholds static while beats are in flight; the block does not enforce it
  assign q_entry.is_tick   = in_data.req_type;
  assign q_entry.last      = in_data.last_pulse;
  assign q_entry.above_mid = in_data.pulse_duration > cfg.pulse_mid;
  assign q_entry.above_max = in_data.pulse_duration > cfg.pulse_max;
  assign q_entry.below_mid = in_data.pulse_duration < cfg.pulse_mid;

endmodule

// ===== sv/dpwd_queue.sv =====
// Small FIFO of classified beats between front and back.
`include "assert_macros.svh"
module dpwd_queue #(
  parameter int unsigned QUEUE_DEPTH = dpwd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  dpwd_pkg::pulse_class_t push_data,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output dpwd_pkg::pulse_class_t head_data
);
  import dpwd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  pulse_class_t     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `DPWD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_FULL)
  `DPWD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full)
  `DPWD_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head_valid)

endmodule

// ===== sv/dpwd_back.sv =====
// Back end: pair decoding, packet checks, repeat filter and result register.
`include "assert_macros.svh"
module dpwd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dpwd_pkg::cfg_t         cfg,
  input  logic                   head_valid,
  input  dpwd_pkg::pulse_class_t head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dpwd_pkg::out_item_t    out_data
);
  import dpwd_pkg::*;

  logic [6:0]  pulse_index_r, pulse_index_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic        held_above_mid_r, held_above_mid_nxt;
  logic        held_above_max_r, held_above_max_nxt;
  logic        packet_error_r, packet_error_nxt;
  logic [31:0] prev_code_r, prev_code_nxt;
  logic [31:0] ms_count_r, ms_count_nxt;
  logic [31:0] prev_time_r, prev_time_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        closing;
  logic        out_take;

  assign out_take = out_valid_r && out_ready;
  assign closing  = head_data.last && !head_data.is_tick;
  // a closing pulse needs the result register free or being taken; others always drain
  assign pop      = head_valid && (!closing || !out_valid_r || out_ready);

  always_comb begin
    logic [6:0]  idx_inc;
    logic [31:0] code;
    logic [31:0] elapsed;
    logic        good;
    logic        fresh;
    chime_t      chime;

    pulse_index_nxt    = pulse_index_r;
    shift_nxt          = shift_r;
    held_above_mid_nxt = held_above_mid_r;
    held_above_max_nxt = held_above_max_r;
    packet_error_nxt   = packet_error_r;
    prev_code_nxt      = prev_code_r;
    ms_count_nxt       = ms_count_r;
    prev_time_nxt      = prev_time_r;
    out_valid_nxt      = out_take ? 1'b0 : out_valid_r;
    out_data_nxt       = out_data_r;

    idx_inc = (pulse_index_r != PULSE_IDX_MAX) ? pulse_index_r + 1'b1 : pulse_index_r;
    code    = '0;
    elapsed = ms_count_r - prev_time_r;
    good    = 1'b0;
    fresh   = 1'b0;
    chime   = chime_map(8'd0);

    if (pop) begin
      if (head_data.is_tick) begin
        ms_count_nxt = ms_count_r + 1'b1;
      end else begin
        pulse_index_nxt = idx_inc;
        if (idx_inc <= LAST_PAIR_PULSE) begin
          if (idx_inc[0]) begin
            held_above_mid_nxt = head_data.above_mid;
            held_above_max_nxt = head_data.above_max;
          end else begin
            shift_nxt = {shift_r[30:0], 1'b0};
            if (held_above_mid_r) begin
              if (held_above_max_r || head_data.above_mid) begin
                packet_error_nxt = 1'b1;
              end else begin
                shift_nxt[0] = 1'b1;
              end
            end else if (head_data.below_mid) begin
              packet_error_nxt = 1'b1;
            end
          end
        end

        if (head_data.last) begin
          code  = shift_nxt;
          chime = chime_map(code[7:0]);
          good  = (idx_inc == PULSE_COUNT) && !packet_error_nxt &&
                  (code != '0) && (code[15:8] == 8'd0);
          fresh = (code != prev_code_r) || (elapsed > {16'd0, cfg.window_ms});

          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = STATUS_REJECT;
          out_data_nxt.device_id    = '0;
          out_data_nxt.chime_number = '0;
          if (good) begin
            if (!fresh) begin
              out_data_nxt.status       = STATUS_REPEAT;
              out_data_nxt.device_id    = code[31:16];
              out_data_nxt.chime_number = chime.valid ? chime.index : 2'd0;
              prev_time_nxt             = ms_count_r;
            end else begin
              prev_code_nxt = code;
              if (chime.valid) begin
                out_data_nxt.status       = STATUS_NEW;
                out_data_nxt.device_id    = code[31:16];
                out_data_nxt.chime_number = chime.index;
                prev_time_nxt             = ms_count_r;
              end
            end
          end

          pulse_index_nxt    = '0;
          shift_nxt          = '0;
          held_above_mid_nxt = 1'b0;
          held_above_max_nxt = 1'b0;
          packet_error_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_index_r    <= '0;
      shift_r          <= '0;
      held_above_mid_r <= 1'b0;
      held_above_max_r <= 1'b0;
      packet_error_r   <= 1'b0;
      prev_code_r      <= '0;
      ms_count_r       <= '0;
      prev_time_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      pulse_index_r    <= pulse_index_nxt;
      shift_r          <= shift_nxt;
      held_above_mid_r <= held_above_mid_nxt;
      held_above_max_r <= held_above_max_nxt;
      packet_error_r   <= packet_error_nxt;
      prev_code_r      <= prev_code_nxt;
      ms_count_r       <= ms_count_nxt;
      prev_time_r      <= prev_time_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DPWD_ASSERT_IMPL(a_reject_zeroed, clk, rst_n,
    out_valid_r && (out_data_r.status == STATUS_REJECT),
    (out_data_r.device_id == 16'd0) && (out_data_r.chime_number == 2'd0))
  `DPWD_ASSERT_NEXT(a_close_clears, clk, rst_n, pop && closing,
    (pulse_index_r == 7'd0) && !packet_error_r && (shift_r == 32'd0) && out_valid_r)
  `DPWD_ASSERT_NEXT(a_tick_keeps_packet, clk, rst_n, pop && head_data.is_tick,
    $stable(pulse_index_r) && $stable(shift_r) && $stable(packet_error_r))

endmodule
